/* hw/rtl/sfot_pkg.sv */
// Package for the spectral flux onset trigger.
// Field widths, register indexes, controller/datapath command and status types.
// No dependencies.
`default_nettype none

package sfot_pkg;

    localparam int AMP_W       = 16;
    localparam int FLUX_W      = 24;
    localparam int THR_W       = 24;
    localparam int TC_W        = 13;
    localparam int TIDX_W      = 12;
    localparam int CFG_W       = 24;
    localparam int PROD_W      = FLUX_W + TC_W;
    localparam int PQ_W        = PROD_W - 16;
    localparam int DIV_STEPS   = 16;
    localparam int ITER_W      = 5;

    // divide by five as multiply by ceil(2^23 / 5), exact for inputs below 2^22
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 23;
    localparam int CD_MUL_W    = PQ_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP5 = 21'd1677722;

    localparam logic [TC_W-1:0] MAX_TARGETS = 13'd4096;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_TARGET    = 1'b1;

    typedef struct packed {
        logic clear_step;
        logic load_bin;
        logic load_last;
        logic read_issue;
        logic div_load;
        logic div_step;
        logic sq_calc;
        logic acc_write;
        logic sqrt_load;
        logic sqrt_step;
        logic mul_calc;
        logic cdiv_load;
        logic out_load;
    } sfot_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic idx_last;
        logic div_skip;
        logic out_free;
    } sfot_status_t;

endpackage

`default_nettype wire

/* hw/rtl/sfot_ctrl.sv */
// Controller state machine of the spectral flux onset trigger.
// Sequences clear, bin load, frame walk, square root and index map; uses sfot_pkg.
`default_nettype none

module sfot_ctrl
    import sfot_pkg::*;
#(
    parameter int SQRT_STEPS = 21
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tlast,
    output logic              s_tready,
    input  wire sfot_status_t status,
    output sfot_cmd_t         cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_READ   = 4'd2;
    localparam logic [3:0] ST_DLOAD  = 4'd3;
    localparam logic [3:0] ST_DIV    = 4'd4;
    localparam logic [3:0] ST_SQ     = 4'd5;
    localparam logic [3:0] ST_ACC    = 4'd6;
    localparam logic [3:0] ST_SQLOAD = 4'd7;
    localparam logic [3:0] ST_SQRT   = 4'd8;
    localparam logic [3:0] ST_MUL    = 4'd9;
    localparam logic [3:0] ST_CDLOAD = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;

    localparam logic [ITER_W-1:0] DIV_LAST  = ITER_W'(DIV_STEPS - 1);
    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);

    logic [3:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_bin  = 1'b1;
                    cmd.load_last = s_tlast;
                    if (s_tlast) state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_issue = 1'b1;
                state_next     = ST_DLOAD;
            end
            ST_DLOAD: begin
                cmd.div_load = 1'b1;
                iter_next    = '0;
                state_next   = status.div_skip ? ST_SQ : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST) state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq_calc = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_write = 1'b1;
                state_next    = status.idx_last ? ST_SQLOAD : ST_READ;
            end
            ST_SQLOAD: begin
                cmd.sqrt_load = 1'b1;
                iter_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 1'b1;
                if (iter_reg == SQRT_LAST) state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_calc = 1'b1;
                state_next   = ST_CDLOAD;
            end
            ST_CDLOAD: begin
                cmd.cdiv_load = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/sfot_dp.sv */
// Datapath of the spectral flux onset trigger: bin memories, divider, squarer,
// accumulator, square root, index map and output register; uses sfot_pkg.
`default_nettype none

module sfot_dp
    import sfot_pkg::*;
#(
    parameter int BIN_COUNT  = 512,
    parameter int SQRT_STEPS = 21
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sfot_cmd_t          cmd,
    output sfot_status_t            status,
    input  wire logic [AMP_W-1:0]   bin_amplitude,
    input  wire logic               ready_gate,
    input  wire logic               cfg_we,
    input  wire logic [0:0]         cfg_addr,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [FLUX_W-1:0]       flux,
    output logic                    onset,
    output logic [TIDX_W-1:0]       start_index,
    output logic [TIDX_W-1:0]       end_index
);

    localparam int IDX_W = $clog2(BIN_COUNT);
    localparam int CNT_W = $clog2(BIN_COUNT + 1);
    localparam int SUM_W = 32 + IDX_W;
    localparam int SRC_W = 2 * SQRT_STEPS;
    localparam int REM_W = SQRT_STEPS + 2;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(BIN_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BIN_COUNT);

    // memories
    logic [AMP_W-1:0] cur_mem  [BIN_COUNT];
    logic [AMP_W-1:0] prev_mem [BIN_COUNT];
    logic [AMP_W-1:0] cur_q_reg, prev_q_reg;

    // control and state
    logic [THR_W-1:0]  thr_reg;
    logic [TC_W-1:0]   tc_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [AMP_W-1:0]  peak_reg;
    logic              gate_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [FLUX_W-1:0] prev_flux_reg;
    logic [TIDX_W-1:0] start_reg, end_reg;
    logic              m_valid_reg;

    // arithmetic
    logic [AMP_W-1:0]      div_r_reg, q_reg;
    logic [2*AMP_W-1:0]    sq_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SRC_W-1:0]      src_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SQRT_STEPS-1:0] root_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PQ_W-1:0]       cd_reg;
    logic [FLUX_W-1:0]     flux_reg;
    logic [FLUX_W-1:0]     out_flux_reg;
    logic                  onset_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_bin && count_reg < CNT_MAX) begin
            cur_mem[count_reg[IDX_W-1:0]] <= bin_amplitude;
        end
        if (cmd.read_issue) begin
            cur_q_reg <= cur_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            prev_mem[idx_reg] <= '0;
        end else if (cmd.acc_write) begin
            prev_mem[idx_reg] <= q_reg;
        end
        if (cmd.read_issue) begin
            prev_q_reg <= prev_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_W'(32768);
            tc_reg  <= TC_W'(256);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_THRESHOLD: thr_reg <= cfg_wdata[THR_W-1:0];
                REG_TARGET:    tc_reg  <= cfg_wdata[TC_W-1:0];
                default:       ;
            endcase
        end
    end

    assign status.clear_done = (idx_reg == IDX_MAX);
    assign status.idx_last   = (CNT_W'(idx_reg) + 1'b1 == count_reg);
    assign status.div_skip   = (peak_reg == '0) || (cur_q_reg >= peak_reg);
    assign status.out_free   = !m_valid_reg || m_tready;

    // divider step: remainder stays below the peak
    logic [AMP_W:0] div_t;
    assign div_t = {div_r_reg, 1'b0};

    // squared difference
    logic signed [AMP_W:0] diff;
    logic [AMP_W-1:0]      diff_abs;
    assign diff     = $signed({1'b0, q_reg}) - $signed({1'b0, prev_q_reg});
    assign diff_abs = diff[AMP_W] ? AMP_W'(-diff) : diff[AMP_W-1:0];

    // square root step
    logic [REM_W-1:0] sq_rem_t, sq_trial;
    assign sq_rem_t = {rem_reg[REM_W-3:0], src_reg[SRC_W-1:SRC_W-2]};
    assign sq_trial = {root_reg, 2'b01};

    // divide by five through the reciprocal
    logic [CD_MUL_W-1:0] cd_mul;
    assign cd_mul = CD_MUL_W'(prod_reg[PROD_W-1:16]) * CD_MUL_W'(RECIP5);

    // end index saturation and onset decision
    logic [FLUX_W-1:0] change;
    logic [TC_W-1:0]   limit, limit_m1;
    logic [TIDX_W-1:0] end_calc;
    logic              onset_calc;
    always_comb begin
        change   = (flux_reg >= prev_flux_reg) ? flux_reg - prev_flux_reg
                                               : prev_flux_reg - flux_reg;
        limit    = (tc_reg > MAX_TARGETS) ? MAX_TARGETS : tc_reg;
        limit_m1 = limit - 1'b1;
        if (tc_reg == '0) begin
            end_calc = '0;
        end else if (cd_reg > PQ_W'(limit_m1)) begin
            end_calc = limit_m1[TIDX_W-1:0];
        end else begin
            end_calc = cd_reg[TIDX_W-1:0];
        end
        onset_calc = gate_reg && (change >= thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            peak_reg      <= '0;
            idx_reg       <= '0;
            prev_flux_reg <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            m_valid_reg   <= 1'b0;
            gate_reg      <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                idx_reg <= (idx_reg == IDX_MAX) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.load_bin && count_reg < CNT_MAX) begin
                count_reg <= count_reg + 1'b1;
                if (bin_amplitude > peak_reg) peak_reg <= bin_amplitude;
            end
            if (cmd.load_last) begin
                gate_reg <= ready_gate;
            end
            if (cmd.acc_write) begin
                idx_reg <= status.idx_last ? '0 : idx_reg + 1'b1;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg   <= 1'b1;
                prev_flux_reg <= flux_reg;
                count_reg     <= '0;
                peak_reg      <= '0;
                if (onset_calc) begin
                    start_reg <= end_reg;
                    end_reg   <= end_calc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_last) begin
            sum_reg <= '0;
        end
        if (cmd.div_load) begin
            div_r_reg <= cur_q_reg;
            if (peak_reg == '0) begin
                q_reg <= cur_q_reg;
            end else if (cur_q_reg >= peak_reg) begin
                q_reg <= '1;
            end else begin
                q_reg <= '0;
            end
        end
        if (cmd.div_step) begin
            if (div_t >= {1'b0, peak_reg}) begin
                div_r_reg <= AMP_W'(div_t - {1'b0, peak_reg});
                q_reg     <= {q_reg[AMP_W-2:0], 1'b1};
            end else begin
                div_r_reg <= div_t[AMP_W-1:0];
                q_reg     <= {q_reg[AMP_W-2:0], 1'b0};
            end
        end
        if (cmd.sq_calc) begin
            sq_reg <= diff_abs * diff_abs;
        end
        if (cmd.acc_write) begin
            sum_reg <= sum_reg + SUM_W'(sq_reg);
        end
        if (cmd.sqrt_load) begin
            src_reg  <= SRC_W'(sum_reg);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            src_reg <= {src_reg[SRC_W-3:0], 2'b00};
            if (sq_rem_t >= sq_trial) begin
                rem_reg  <= sq_rem_t - sq_trial;
                root_reg <= {root_reg[SQRT_STEPS-2:0], 1'b1};
            end else begin
                rem_reg  <= sq_rem_t;
                root_reg <= {root_reg[SQRT_STEPS-2:0], 1'b0};
            end
        end
        if (cmd.mul_calc) begin
            flux_reg <= FLUX_W'(root_reg);
            prod_reg <= PROD_W'(FLUX_W'(root_reg)) * PROD_W'(tc_reg);
        end
        if (cmd.cdiv_load) begin
            cd_reg <= PQ_W'(cd_mul[CD_MUL_W-1:RECIP_SHIFT]);
        end
        if (cmd.out_load) begin
            onset_reg    <= onset_calc;
            out_flux_reg <= flux_reg;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign flux        = out_flux_reg;
    assign onset       = onset_reg;
    assign start_index = start_reg;
    assign end_index   = end_reg;

endmodule

`default_nettype wire

/* hw/rtl/spectral_flux_onset_trigger_unit.sv */
// Top level of the spectral flux onset trigger.
// Joins sfot_ctrl and sfot_dp; uses sfot_pkg.
//
//  channel  | direction | tdata (low bit up)                    | side bits
//  ---------+-----------+---------------------------------------+----------------------
//  s_       | in        | bin_amplitude[15:0]                   | tlast last_bin, tuser ready_gate
//  m_       | out       | flux[23:0] start_index end_index      | tuser onset
//  cfg_     | in        | 0 flux_change_threshold, 1 target_count | write only
//
// A non-final bin is stored and the unit stays ready for the next one. The final
// bin starts a walk over the stored bins (read, divider load, 16 divider steps,
// square, add, with the divider steps skipped when the peak is zero or the bin
// is at the peak); then a load and SQRT_STEPS square root steps, a multiply, a
// reciprocal multiply for the divide by five and the output load.
// After reset the previous-frame memory is swept to zero with s_tready low. A
// result waiting on m_tready holds its register while bins of the next frame
// keep flowing; a walk holds at its end until the output register is free.
`default_nettype none

module spectral_flux_onset_trigger_unit
    import sfot_pkg::*;
#(
    parameter int BIN_COUNT = 512
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // bin_amplitude[15:0]
    input  wire logic              s_tlast,   // last_bin
    input  wire logic              s_tuser,   // ready_gate
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,   // flux[23:0], start_index[35:24], end_index[47:36]
    output logic                   m_tuser,   // onset
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    // square root digits cover the widest possible sum of squares
    localparam int SQRT_STEPS = (32 + $clog2(BIN_COUNT) + 1) / 2;

    sfot_cmd_t         cmd;
    sfot_status_t      status;
    logic [FLUX_W-1:0] flux;
    logic [TIDX_W-1:0] start_index, end_index;

    sfot_ctrl #(
        .SQRT_STEPS(SQRT_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfot_dp #(
        .BIN_COUNT (BIN_COUNT),
        .SQRT_STEPS(SQRT_STEPS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .bin_amplitude (s_tdata),
        .ready_gate    (s_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .flux          (flux),
        .onset         (m_tuser),
        .start_index   (start_index),
        .end_index     (end_index)
    );

    // pack result fields, lowest first
    assign m_tdata = {end_index, start_index, flux};

endmodule

`default_nettype wire
